[design/chc_pkg.sv]
// Package: payload types, codes and constants of the climate hysteresis controller.
package chc_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 24;

	typedef enum logic [CfgIdxW-1:0] {
		REG_FAN_UP      = 3'd0,
		REG_FAN_DOWN    = 3'd1,
		REG_HUMID_ON    = 3'd2,
		REG_HUMID_OFF   = 3'd3,
		REG_HEAT_ALERT  = 3'd4,
		REG_DRY_ALERT   = 3'd5,
		REG_NIGHT_WIN   = 3'd6,
		REG_NIGHT_CAP   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		THEME_DAY   = 2'd0,
		THEME_COZY  = 2'd1,
		THEME_NIGHT = 2'd2
	} theme_t;

	typedef enum logic [1:0] {
		ALERT_NONE   = 2'd0,
		ALERT_HEAT   = 2'd1,
		ALERT_DRY    = 2'd2,
		ALERT_SENSOR = 2'd3
	} alert_t;

	typedef struct packed {
		logic              sample_valid;
		logic [4:0]        hour_of_day;
		logic signed [7:0] temperature;
		logic [6:0]        humidity;
		logic [7:0]        ambient_light;
	} sample_t;

	typedef struct packed {
		logic [1:0] fan_speed;
		logic       pump_enable;
		logic [6:0] backlight_level;
		theme_t     theme_code;
		alert_t     alert_code;
	} decision_t;

	localparam logic [23:0] FanUpRst    = 24'd2104602;
	localparam logic [23:0] FanDownRst  = 24'd2038809;
	localparam logic [6:0]  HumidOnRst  = 7'd40;
	localparam logic [6:0]  HumidOffRst = 7'd45;
	localparam logic [7:0]  HeatRst     = 8'd35;
	localparam logic [6:0]  DryRst      = 7'd25;
	localparam logic [12:0] NightWinRst = 13'd1558;
	localparam logic [6:0]  NightCapRst = 7'd30;

	localparam logic [7:0] BlFloor    = 8'd10;
	localparam logic [6:0] BlFailDay  = 7'd60;
	localparam logic [7:0] BlMax      = 8'd100;
	localparam logic [7:0] CozyLight  = 8'd30;
	localparam logic [1:0] FanMax     = 2'd3;

endpackage

[design/climate_hysteresis_controller.sv]
// Top level: climate hysteresis controller with input and result registers.
//
// Usage:
//   in_valid/in_stall/in_data carry sensor snapshot requests; out_valid/out_stall/out_data
//   carry one decision per request, in order. A request is taken on a clock edge with
//   valid high and stall low.
//   cfg_we/cfg_index/cfg_data write a control register; write only while no request
//   is in flight.
// Flow: a taken request waits in the input register until its decision is registered
//   (out_valid high from then on). One request per cycle while out_stall is low; fan and
//   pump state is updated in that same cycle, so the next request sees it at once.
// Stall: when out_stall holds a pending decision, the input register keeps its request
//   and in_stall rises while it is full, so nothing is dropped and the decision holds.
// Reset: arst_n clears both valids, turns fan and pump off and loads the register
//   defaults (thresholds 26/29/32 up, 25/28/31 down, pump 40/45, heat 35, dry 25,
//   night 22 to 6, night cap 30).
module climate_hysteresis_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  chc_pkg::sample_t             in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output chc_pkg::decision_t           out_data,
	input  logic                         cfg_we,
	input  logic [chc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [chc_pkg::CfgDataW-1:0] cfg_data
);
	import chc_pkg::*;

	logic [23:0] fan_up_q;
	logic [23:0] fan_drop_q;
	logic [6:0]  hum_lo_q;
	logic [6:0]  hum_hi_q;
	logic [7:0]  heat_q;
	logic [6:0]  dry_q;
	logic [12:0] night_win_q;
	logic [6:0]  night_cap_q;

	logic [1:0] fan_lvl_q;
	logic       pump_q;

	logic      valid_s1;
	sample_t   data_s1;
	logic      valid_s2;
	decision_t data_s2;

	logic      adv;
	logic      load_s1;
	logic      night;
	logic [7:0] win_start;
	logic [7:0] hour_ext;
	logic [7:0] win_end;
	logic [1:0] lvl;
	logic       pump_nx;
	logic [7:0] bl_floor;
	logic [7:0] bl_cap;
	logic [7:0] cap_ext;
	decision_t  dec;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign load_s1  = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_up_q    <= FanUpRst;
			fan_drop_q  <= FanDownRst;
			hum_lo_q    <= HumidOnRst;
			hum_hi_q    <= HumidOffRst;
			heat_q      <= HeatRst;
			dry_q       <= DryRst;
			night_win_q <= NightWinRst;
			night_cap_q <= NightCapRst;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FAN_UP:     fan_up_q    <= cfg_data;
				REG_FAN_DOWN:   fan_drop_q  <= cfg_data;
				REG_HUMID_ON:   hum_lo_q    <= cfg_data[6:0];
				REG_HUMID_OFF:  hum_hi_q    <= cfg_data[6:0];
				REG_HEAT_ALERT: heat_q      <= cfg_data[7:0];
				REG_DRY_ALERT:  dry_q       <= cfg_data[6:0];
				REG_NIGHT_WIN:  night_win_q <= cfg_data[12:0];
				REG_NIGHT_CAP:  night_cap_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Decision logic
	always_comb begin
		win_start = night_win_q[7:0];
		win_end   = {3'b000, night_win_q[12:8]};
		hour_ext  = {3'b000, data_s1.hour_of_day};
		if (win_start <= win_end) begin
			night = (hour_ext >= win_start) && (hour_ext < win_end);
		end else begin
			night = (hour_ext >= win_start) || (hour_ext < win_end);
		end

		lvl = fan_lvl_q;
		for (int k = 0; k < 3; k++) begin
			if (lvl < FanMax && data_s1.temperature >= $signed(fan_up_q[8*lvl +: 8])) begin
				lvl = lvl + 2'd1;
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (lvl > 2'd0 &&
			    data_s1.temperature < $signed(fan_drop_q[8*(lvl-2'd1) +: 8])) begin
				lvl = lvl - 2'd1;
			end
		end

		priority if (data_s1.humidity < hum_lo_q) begin
			pump_nx = 1'b1;
		end else if (data_s1.humidity >= hum_hi_q) begin
			pump_nx = 1'b0;
		end else begin
			pump_nx = pump_q;
		end

		cap_ext  = {1'b0, night_cap_q};
		bl_floor = (data_s1.ambient_light < BlFloor) ? BlFloor : data_s1.ambient_light;
		bl_cap   = (night && bl_floor > cap_ext) ? cap_ext : bl_floor;

		if (!data_s1.sample_valid) begin
			dec.fan_speed       = fan_lvl_q;
			dec.pump_enable     = pump_q;
			dec.alert_code      = ALERT_SENSOR;
			dec.theme_code      = night ? THEME_NIGHT : THEME_DAY;
			if (night) begin
				dec.backlight_level = (cap_ext > BlMax) ? BlMax[6:0] : night_cap_q;
			end else begin
				dec.backlight_level = BlFailDay;
			end
		end else begin
			dec.fan_speed       = lvl;
			dec.pump_enable     = pump_nx;
			dec.backlight_level = (bl_cap > BlMax) ? BlMax[6:0] : bl_cap[6:0];
			priority if (night) begin
				dec.theme_code = THEME_NIGHT;
			end else if (data_s1.ambient_light < CozyLight) begin
				dec.theme_code = THEME_COZY;
			end else begin
				dec.theme_code = THEME_DAY;
			end
			priority if (data_s1.temperature >= $signed(heat_q)) begin
				dec.alert_code = ALERT_HEAT;
			end else if (data_s1.humidity < dry_q) begin
				dec.alert_code = ALERT_DRY;
			end else begin
				dec.alert_code = ALERT_NONE;
			end
		end
	end

	// Pipeline control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			fan_lvl_q <= 2'd0;
			pump_q    <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= valid_s1;
				if (valid_s1 && data_s1.sample_valid) begin
					fan_lvl_q <= lvl;
					pump_q    <= pump_nx;
				end
			end
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			data_s1 <= in_data;
		end
		if (adv && valid_s1) begin
			data_s2 <= dec;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

`ifndef SYNTHESIS
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |-> in_stall)
		else $error("input taken while both stages are blocked");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && valid_s1 && data_s1.sample_valid) |=> ($stable(fan_lvl_q) && $stable(pump_q)))
		else $error("fan or pump state moved without a good sample");

	a_fail_holds_fan: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && !data_s1.sample_valid) |=>
		(out_data.fan_speed == $past(fan_lvl_q) && out_data.alert_code == ALERT_SENSOR))
		else $error("sensor failure decision does not hold the fan");

	a_backlight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.backlight_level <= BlMax[6:0]))
		else $error("backlight above full scale");
`endif

endmodule
